// File: design/mi_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the modular inverse block.
// No dependencies; used by mi_cell and modular_inverse.
package mi_pkg;

  localparam int WORD_BITS_DEF = 31;

  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_NOINV = 2'd1;
  localparam logic [1:0] ST_MZERO = 2'd2;

  // per-cycle command broadcast to every bit slice
  typedef struct packed {
    logic load;
    logic step;
  } mi_ctl_t;

endpackage

// File: design/mi_cell.sv
`timescale 1ns / 1ps
// One bit slice of the shift-subtract divider with quotient-times-coefficient
// accumulator. Depends on mi_pkg for the command struct.
module mi_cell (
  input  logic             clk,
  input  mi_pkg::mi_ctl_t  ctl,
  input  logic             ld_bit,
  input  logic             rem_in,
  input  logic             dvd_in,
  input  logic             acc_in,
  input  logic             dsr_bit,
  input  logic             u_bit,
  input  logic             borrow_in,
  output logic             borrow_out,
  input  logic             carry_in,
  output logic             carry_out,
  input  logic             ge,
  output logic             rem_q,
  output logic             dvd_q,
  output logic             acc_q
);

  logic rem_r, dvd_r, acc_r;
  logic diff, add_y, sum;

  // rem_in is the shifted partial remainder bit for this slice
  assign diff       = rem_in ^ dsr_bit ^ borrow_in;
  assign borrow_out = (~rem_in & dsr_bit) | (~(rem_in ^ dsr_bit) & borrow_in);

  assign add_y     = u_bit & ge;
  assign sum       = acc_in ^ add_y ^ carry_in;
  assign carry_out = (acc_in & add_y) | (carry_in & (acc_in ^ add_y));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem_r <= 1'b0;
      dvd_r <= ld_bit;
      acc_r <= 1'b0;
    end else if (ctl.step) begin
      rem_r <= ge ? diff : rem_in;
      dvd_r <= dvd_in;
      acc_r <= sum;
    end
  end

  assign rem_q = rem_r;
  assign dvd_q = dvd_r;
  assign acc_q = acc_r;

endmodule

// File: design/modular_inverse.sv
`timescale 1ns / 1ps
// Modular inverse by extended Euclid; top level. Depends on mi_pkg, mi_cell.
// The initial reduction and each Euclid quotient step run on the bit-serial
// divider row (one quotient bit per cycle); a zero modulus skips the divider.
// One word at a time.
// Reset (rst_n, synchronous) returns to idle and drops any pending result.
module modular_inverse #(
  parameter int WORD_BITS = mi_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WORD_BITS-1:0] in_value,
  input  logic [WORD_BITS-1:0] in_modulus,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_BITS-1:0] out_inverse,
  output logic [WORD_BITS-1:0] out_common_divisor,
  output logic [1:0]           out_status
);

  localparam int CW = $clog2(WORD_BITS);
  localparam logic [CW-1:0] LAST = CW'(WORD_BITS - 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RED  = 7'b0000010,
    S_RDN  = 7'b0000100,
    S_CHK  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_UPD  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [WORD_BITS-1:0] m_r, r0_r, r1_r, u0_r, u1_r;
  logic                 neg0_r, neg1_r;
  logic                 out_valid_r;
  logic [WORD_BITS-1:0] out_inv_r, out_gcd_r;
  logic [1:0]           out_st_r;

  mi_pkg::mi_ctl_t      ctl;
  logic [WORD_BITS-1:0] ld_w, rem_w, dvd_w, acc_w, bor_w, car_w;
  logic [WORD_BITS-1:0] rem_in_w, dvd_in_w, acc_in_w, bin_w, cin_w;
  logic                 ge;
  logic                 accept, fin_go;
  logic [WORD_BITS-1:0] inv_t, inv_f;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign fin_go = (state_r == S_FIN) && !(out_valid_r && out_stall);

  assign ctl = '{
    load: (accept && (in_modulus != '0)) || ((state_r == S_CHK) && (r1_r != '0)),
    step: (state_r == S_RED) || (state_r == S_DIV)
  };
  assign ld_w     = (state_r == S_IDLE) ? in_value : r0_r;

  // neighbor links: each slice takes the bit below it
  assign rem_in_w = {rem_w[WORD_BITS-2:0], dvd_w[WORD_BITS-1]};
  assign dvd_in_w = {dvd_w[WORD_BITS-2:0], 1'b0};
  assign acc_in_w = {acc_w[WORD_BITS-2:0], 1'b0};
  assign bin_w    = {bor_w[WORD_BITS-2:0], 1'b0};
  assign cin_w    = {car_w[WORD_BITS-2:0], 1'b0};
  // shifted remainder overflowed the top slice, or no final borrow
  assign ge = rem_w[WORD_BITS-1] | ~bor_w[WORD_BITS-1];

  for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
    mi_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .ld_bit    (ld_w[i]),
      .rem_in    (rem_in_w[i]),
      .dvd_in    (dvd_in_w[i]),
      .acc_in    (acc_in_w[i]),
      .dsr_bit   (r1_r[i]),
      .u_bit     (u1_r[i]),
      .borrow_in (bin_w[i]),
      .borrow_out(bor_w[i]),
      .carry_in  (cin_w[i]),
      .carry_out (car_w[i]),
      .ge        (ge),
      .rem_q     (rem_w[i]),
      .dvd_q     (dvd_w[i]),
      .acc_q     (acc_w[i])
    );
  end

  // coefficient magnitude never exceeds m, so u0 mod m is a single compare
  assign inv_t = (u0_r == m_r) ? '0 : u0_r;
  assign inv_f = (neg0_r && (inv_t != '0)) ? (m_r - inv_t) : inv_t;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (accept) state_nxt = (in_modulus == '0) ? S_FIN : S_RED;
      end
      S_RED: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) state_nxt = S_RDN;
      end
      S_RDN: state_nxt = S_CHK;
      S_CHK: begin
        cnt_nxt   = '0;
        state_nxt = (r1_r == '0) ? S_FIN : S_DIV;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) state_nxt = S_UPD;
      end
      S_UPD: state_nxt = S_CHK;
      S_FIN: if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (fin_go)                      out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_r  <= in_modulus;
      r0_r <= in_value;
      r1_r <= in_modulus;
    end
    if (state_r == S_RDN) begin
      r0_r   <= m_r;
      r1_r   <= rem_w;
      u0_r   <= '0;
      u1_r   <= WORD_BITS'(1);
      neg0_r <= 1'b0;
      neg1_r <= 1'b0;
    end
    if (state_r == S_UPD) begin
      r0_r   <= r1_r;
      r1_r   <= rem_w;
      u0_r   <= u1_r;
      u1_r   <= u0_r + acc_w;
      neg0_r <= neg1_r;
      neg1_r <= ~neg1_r;
    end
    if (fin_go) begin
      out_gcd_r <= r0_r;
      if (m_r == '0) begin
        out_inv_r <= '0;
        out_st_r  <= mi_pkg::ST_MZERO;
      end else if (r0_r != WORD_BITS'(1)) begin
        out_inv_r <= '0;
        out_st_r  <= mi_pkg::ST_NOINV;
      end else begin
        out_inv_r <= inv_f;
        out_st_r  <= mi_pkg::ST_FOUND;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_inverse        = out_inv_r;
  assign out_common_divisor = out_gcd_r;
  assign out_status         = out_st_r;

  a_rem_below_dsr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_w < r1_r))
    else $error("partial remainder not below divisor");

  a_found_gcd_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == mi_pkg::ST_FOUND)) |-> (out_common_divisor == WORD_BITS'(1)))
    else $error("inverse reported with gcd other than one");

  a_noinv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != mi_pkg::ST_FOUND)) |-> (out_inverse == '0))
    else $error("nonzero inverse without an inverse");

  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> out_valid_r && (state_r == S_IDLE))
    else $error("result not posted after finish");

endmodule
